>>> design/btalloc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btalloc_pkg
// shared types and constants of the boundary-tag first-fit allocator
// ----------------------------------------------------------------------------
package btalloc_pkg;

  localparam int HEAP_BYTES_DEF = 1024;
  localparam int ELEM_BYTES_DEF = 8;

  // one tag word, and the pair of tags that bounds every block
  localparam int TAG_BYTES  = 8;
  localparam int TAG_SHIFT  = 3;
  localparam int PAIR_BYTES = 2 * TAG_BYTES;

  localparam int COUNT_W  = 7;
  localparam int ADDR_W   = 10;
  localparam int FREE_W   = 10;

  // tag writes queued by one request: two for a whole block or a merge, four for a split
  localparam int WQ_DEPTH = 4;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_EXCEEDS      = 3'd1,
    STAT_NO_FIT       = 3'd2,
    STAT_INVALID      = 3'd3,
    STAT_ALREADY_FREE = 3'd4
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  address;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] block_address;
    logic [FREE_W-1:0] free_left;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_WALK,
    S_F_WALK,
    S_F_LEAD,
    S_F_END,
    S_F_PREV,
    S_F_NEXT,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

>>> design/btalloc_tag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btalloc_tag_ram
// tag word memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module btalloc_tag_ram import btalloc_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF,
  localparam int NWORDS = HEAP_BYTES / TAG_BYTES,
  localparam int IW     = $clog2(NWORDS),
  localparam int TW     = $clog2(HEAP_BYTES) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_addr,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  logic signed [TW-1:0] wr_data,
  output logic signed [TW-1:0] rd_data
);

  localparam logic signed [TW-1:0] RESET_TAG = TW'(HEAP_BYTES - PAIR_BYTES);

  logic signed [TW-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    valid_r;
  logic signed [TW-1:0] q_r;
  logic                 q_valid_r;
  logic                 q_edge_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r       <= mem[rd_addr];
      q_valid_r <= valid_r[rd_addr];
      q_edge_r  <= (rd_addr == '0) || (rd_addr == IW'(NWORDS - 1));
    end
  end

  // unwritten words read as the single free block spanning the heap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = q_valid_r ? q_r : (q_edge_r ? RESET_TAG : '0);

endmodule

>>> design/boundary_tag_first_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// first-fit heap allocator with boundary tags and coalescing on free
// ----------------------------------------------------------------------------
// One transaction at a time: the block stalls its input from acceptance until
// the result is loaded into the output register. Timing is set by the single
// read port of the tag memory, one tag word per cycle, followed by up to four
// tag writes through the same memory. An allocate reads the blocks visited by
// the first-fit walk (42 at most at the default heap size) and, when it finds one,
// writes its tags; one that finds none writes no tags. A free that succeeds reads
// the blocks in front of the freed one, its two tags and its neighbours, then
// writes the merged tags; a rejected free ends early and writes no tags. A zero
// count, a request above the free total, a misaligned address or one below the
// first user area is answered without a memory read. No clearing pass is needed
// after reset: words never written read as one free block spanning the heap.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator import btalloc_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF,
  parameter int ELEM_BYTES = ELEM_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int NWORDS  = HEAP_BYTES / TAG_BYTES;
  localparam int IW      = $clog2(NWORDS);
  localparam int TW      = $clog2(HEAP_BYTES) + 1;
  localparam int FTW     = $clog2(HEAP_BYTES);
  localparam int NEED_W  = $clog2(((2 ** COUNT_W) - 1) * ELEM_BYTES + TAG_BYTES + 1);
  localparam int AW      = ((TW > NEED_W) ? TW : NEED_W) + 2;
  localparam int WQ_IW   = $clog2(WQ_DEPTH);

  typedef logic signed [AW-1:0] num_t;

  localparam num_t NUM_ZERO   = '0;
  localparam num_t NUM_ONE    = AW'(1);
  localparam num_t NUM_TWO    = AW'(2);
  localparam num_t NUM_PAIR   = AW'(PAIR_BYTES);
  localparam num_t NUM_ELEM   = AW'(ELEM_BYTES);
  localparam num_t NUM_TAG_M1 = AW'(TAG_BYTES - 1);
  localparam num_t NUM_NW     = AW'(NWORDS);
  localparam logic [FTW-1:0] FREE_INIT = FTW'(HEAP_BYTES - PAIR_BYTES);

  // sequencer and working registers
  state_t         state_r, state_nxt;
  num_t           w_r, w_nxt;
  num_t           lead_r, lead_nxt;
  num_t           end_r, end_nxt;
  num_t           t_r, t_nxt;
  num_t           need_r, need_nxt;
  num_t           start_r, start_nxt;
  num_t           size_r, size_nxt;
  num_t           gain_r, gain_nxt;
  logic [FTW-1:0] free_r, free_nxt;
  status_t        status_r, status_nxt;
  logic [ADDR_W-1:0] baddr_r, baddr_nxt;

  // pending tag writes
  logic [IW-1:0]        wq_addr_r [WQ_DEPTH];
  logic signed [TW-1:0] wq_data_r [WQ_DEPTH];
  logic [WQ_DEPTH-1:0]  wq_en_r;
  logic [WQ_IW-1:0]     wq_idx_r, wq_idx_nxt;
  num_t                 wq_addr_c [WQ_DEPTH];
  num_t                 wq_data_c [WQ_DEPTH];
  logic [WQ_DEPTH-1:0]  wq_use_c;
  logic                 wq_load_c;

  // memory port
  logic                 rd_en_c;
  num_t                 rd_addr_c;
  logic                 wr_en_c;
  logic [IW-1:0]        wr_addr_c;
  logic signed [TW-1:0] wr_data_c;
  logic signed [TW-1:0] rd_data;

  // shared tag evaluation
  num_t tag_c, mag_c, base_c, end_c, nw_c, need_c, free_num_c, lead_in_c;
  num_t extra_c, need_end_c, split_w_c, extra_end_c;
  num_t next_w_c, prev_w_c, prev_start_c;
  num_t fin_start_c, fin_size_c, fin_gain_c, fin_end_c, free_upd_c;
  logic chain_end_c, alloc_zero_c, alloc_big_c, free_bad_c;
  logic a_fit_c, a_small_c, a_stop_c;
  logic f_walk_more_c, f_walk_bad_c, f_lead_bad_c, f_mismatch_c, f_is_free_c;
  logic lead_pos_c, has_next_c, prev_ok_c, fin_go_c;

  // handshake
  logic      in_fire;
  logic      out_load;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  btalloc_tag_ram #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_tag_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en_c),
    .rd_addr (rd_addr_c[IW-1:0]),
    .wr_en   (wr_en_c),
    .wr_addr (wr_addr_c),
    .wr_data (wr_data_c),
    .rd_data (rd_data)
  );

  // tag word just read, and everything derived from it
  always_comb begin
    tag_c  = AW'(rd_data);
    mag_c  = (tag_c < NUM_ZERO) ? -tag_c : tag_c;
    base_c = (state_r == S_F_LEAD) ? lead_r : w_r;
    // trailing tag of the block whose leading tag was read
    end_c       = base_c + (mag_c >>> TAG_SHIFT) + NUM_ONE;
    chain_end_c = (mag_c == NUM_ZERO) || (end_c >= NUM_NW);
    nw_c        = chain_end_c ? NUM_NW : end_c + NUM_ONE;

    // request decode, size rounded up to whole tag words
    need_c       = ((AW'(in_data.count) * NUM_ELEM + NUM_TAG_M1) >>> TAG_SHIFT) <<< TAG_SHIFT;
    free_num_c   = AW'(free_r);
    alloc_zero_c = (in_data.count == '0);
    alloc_big_c  = need_c > free_num_c;
    free_bad_c   = (in_data.address[TAG_SHIFT-1:0] != '0) ||
                   (in_data.address < ADDR_W'(TAG_BYTES));
    lead_in_c    = AW'(in_data.address >> TAG_SHIFT) - NUM_ONE;

    // first-fit walk
    a_fit_c     = (tag_c > NUM_ZERO) && (tag_c >= need_r);
    extra_c     = tag_c - need_r - NUM_PAIR;
    a_small_c   = extra_c < NUM_ELEM;
    need_end_c  = w_r + (need_r >>> TAG_SHIFT) + NUM_ONE;
    split_w_c   = need_end_c + NUM_ONE;
    extra_end_c = split_w_c + (extra_c >>> TAG_SHIFT) + NUM_ONE;
    a_stop_c    = nw_c >= NUM_NW;

    // free: chain walk up to the leading tag, then tag checks
    f_walk_more_c = (nw_c < lead_r) && (nw_c < NUM_NW);
    f_walk_bad_c  = (nw_c != lead_r) || (lead_r >= NUM_NW);
    f_lead_bad_c  = (tag_c == NUM_ZERO) || (end_c >= NUM_NW);
    f_mismatch_c  = tag_c != t_r;
    f_is_free_c   = t_r > NUM_ZERO;
    lead_pos_c    = lead_r > NUM_ZERO;
    next_w_c      = end_r + NUM_ONE;
    has_next_c    = next_w_c < NUM_NW;
    prev_w_c      = lead_r - NUM_ONE;
    prev_ok_c     = (tag_c > NUM_ZERO) && ((tag_c >>> TAG_SHIFT) + NUM_TWO <= lead_r);
    prev_start_c  = lead_r - (tag_c >>> TAG_SHIFT) - NUM_TWO;

    // merged block as far as the neighbours seen so far
    fin_start_c = start_r;
    fin_size_c  = size_r;
    fin_gain_c  = gain_r;
    if (state_r == S_F_END) begin
      fin_start_c = lead_r;
      fin_size_c  = -t_r;
      fin_gain_c  = -t_r;
    end else if ((state_r == S_F_PREV) && prev_ok_c) begin
      fin_start_c = prev_start_c;
      fin_size_c  = size_r + tag_c + NUM_PAIR;
      fin_gain_c  = gain_r + NUM_PAIR;
    end else if ((state_r == S_F_NEXT) && (tag_c > NUM_ZERO)) begin
      fin_size_c  = size_r + tag_c + NUM_PAIR;
      fin_gain_c  = gain_r + NUM_PAIR;
    end
    fin_end_c = fin_start_c + (fin_size_c >>> TAG_SHIFT) + NUM_ONE;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_ALLOC) begin
            state_nxt = (alloc_zero_c || alloc_big_c) ? S_DONE : S_A_WALK;
          end else if (free_bad_c) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = (lead_in_c == NUM_ZERO) ? S_F_LEAD : S_F_WALK;
          end
        end
      end
      S_A_WALK: begin
        if (a_fit_c) begin
          state_nxt = S_WRITE;
        end else if (a_stop_c) begin
          state_nxt = S_DONE;
        end
      end
      S_F_WALK: begin
        if (!f_walk_more_c) begin
          state_nxt = f_walk_bad_c ? S_DONE : S_F_LEAD;
        end
      end
      S_F_LEAD: state_nxt = f_lead_bad_c ? S_DONE : S_F_END;
      S_F_END: begin
        if (f_mismatch_c || f_is_free_c) begin
          state_nxt = S_DONE;
        end else if (lead_pos_c) begin
          state_nxt = S_F_PREV;
        end else begin
          state_nxt = has_next_c ? S_F_NEXT : S_WRITE;
        end
      end
      S_F_PREV: state_nxt = has_next_c ? S_F_NEXT : S_WRITE;
      S_F_NEXT: state_nxt = S_WRITE;
      S_WRITE: begin
        if (wq_idx_r == WQ_IW'(WQ_DEPTH - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls, memory port and write queue
  always_comb begin
    w_nxt      = w_r;
    lead_nxt   = lead_r;
    end_nxt    = end_r;
    t_nxt      = t_r;
    need_nxt   = need_r;
    start_nxt  = start_r;
    size_nxt   = size_r;
    gain_nxt   = gain_r;
    status_nxt = status_r;
    baddr_nxt  = baddr_r;
    wq_idx_nxt = wq_idx_r;
    free_upd_c = free_num_c;
    fin_go_c   = 1'b0;
    wq_load_c  = 1'b0;
    wq_use_c   = '0;
    for (int i = 0; i < WQ_DEPTH; i++) begin
      wq_addr_c[i] = NUM_ZERO;
      wq_data_c[i] = NUM_ZERO;
    end
    rd_en_c   = 1'b0;
    rd_addr_c = NUM_ZERO;
    wr_en_c   = 1'b0;
    wr_addr_c = '0;
    wr_data_c = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          status_nxt = STAT_OK;
          baddr_nxt  = '0;
          need_nxt   = need_c;
          lead_nxt   = lead_in_c;
          w_nxt      = NUM_ZERO;
          wq_idx_nxt = '0;
          if (in_data.kind == KIND_ALLOC) begin
            if (alloc_zero_c) begin
              status_nxt = STAT_INVALID;
            end else if (alloc_big_c) begin
              status_nxt = STAT_EXCEEDS;
            end else begin
              rd_en_c = 1'b1;
            end
          end else if (free_bad_c) begin
            status_nxt = STAT_INVALID;
          end else begin
            // both the walk and a block at word zero start there
            rd_en_c = 1'b1;
          end
        end
      end
      S_A_WALK: begin
        if (a_fit_c) begin
          baddr_nxt = ADDR_W'((w_r + NUM_ONE) <<< TAG_SHIFT);
          wq_load_c = 1'b1;
          if (a_small_c) begin
            // whole block handed out
            wq_use_c     = WQ_DEPTH'(2'b11);
            wq_addr_c[0] = w_r;
            wq_data_c[0] = -tag_c;
            wq_addr_c[1] = end_c;
            wq_data_c[1] = -tag_c;
            free_upd_c   = free_num_c - tag_c;
          end else begin
            // split: used block in front, free remainder behind
            wq_use_c     = '1;
            wq_addr_c[0] = w_r;
            wq_data_c[0] = -need_r;
            wq_addr_c[1] = need_end_c;
            wq_data_c[1] = -need_r;
            wq_addr_c[2] = split_w_c;
            wq_data_c[2] = extra_c;
            wq_addr_c[3] = extra_end_c;
            wq_data_c[3] = extra_c;
            free_upd_c   = free_num_c - need_r - NUM_PAIR;
          end
        end else if (a_stop_c) begin
          status_nxt = STAT_NO_FIT;
        end else begin
          rd_en_c   = 1'b1;
          rd_addr_c = nw_c;
          w_nxt     = nw_c;
        end
      end
      S_F_WALK: begin
        if (f_walk_more_c) begin
          rd_en_c   = 1'b1;
          rd_addr_c = nw_c;
          w_nxt     = nw_c;
        end else if (f_walk_bad_c) begin
          status_nxt = STAT_INVALID;
        end else begin
          rd_en_c   = 1'b1;
          rd_addr_c = lead_r;
        end
      end
      S_F_LEAD: begin
        if (f_lead_bad_c) begin
          status_nxt = STAT_INVALID;
        end else begin
          t_nxt     = tag_c;
          end_nxt   = end_c;
          rd_en_c   = 1'b1;
          rd_addr_c = end_c;
        end
      end
      S_F_END: begin
        if (f_mismatch_c) begin
          status_nxt = STAT_INVALID;
        end else if (f_is_free_c) begin
          status_nxt = STAT_ALREADY_FREE;
        end else begin
          start_nxt = fin_start_c;
          size_nxt  = fin_size_c;
          gain_nxt  = fin_gain_c;
          if (lead_pos_c) begin
            rd_en_c   = 1'b1;
            rd_addr_c = prev_w_c;
          end else if (has_next_c) begin
            rd_en_c   = 1'b1;
            rd_addr_c = next_w_c;
          end else begin
            fin_go_c = 1'b1;
          end
        end
      end
      S_F_PREV: begin
        start_nxt = fin_start_c;
        size_nxt  = fin_size_c;
        gain_nxt  = fin_gain_c;
        if (has_next_c) begin
          rd_en_c   = 1'b1;
          rd_addr_c = next_w_c;
        end else begin
          fin_go_c = 1'b1;
        end
      end
      S_F_NEXT: fin_go_c = 1'b1;
      S_WRITE: begin
        wr_en_c    = wq_en_r[wq_idx_r];
        wr_addr_c  = wq_addr_r[wq_idx_r];
        wr_data_c  = wq_data_r[wq_idx_r];
        wq_idx_nxt = wq_idx_r + WQ_IW'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase

    // rewrite both tags of the merged block
    if (fin_go_c) begin
      wq_load_c    = 1'b1;
      wq_use_c     = WQ_DEPTH'(2'b11);
      wq_addr_c[0] = fin_start_c;
      wq_data_c[0] = fin_size_c;
      wq_addr_c[1] = fin_end_c;
      wq_data_c[1] = fin_size_c;
      free_upd_c   = free_num_c + fin_gain_c;
    end

    free_nxt = FTW'(free_upd_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      free_r   <= FREE_INIT;
      wq_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      free_r   <= free_nxt;
      wq_idx_r <= wq_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r      <= w_nxt;
    lead_r   <= lead_nxt;
    end_r    <= end_nxt;
    t_r      <= t_nxt;
    need_r   <= need_nxt;
    start_r  <= start_nxt;
    size_r   <= size_nxt;
    gain_r   <= gain_nxt;
    status_r <= status_nxt;
    baddr_r  <= baddr_nxt;
  end

  // out-of-range tag positions are dropped, as the heap edges bound them
  always_ff @(posedge clk) begin
    if (wq_load_c) begin
      for (int i = 0; i < WQ_DEPTH; i++) begin
        wq_en_r[i]   <= wq_use_c[i] && (wq_addr_c[i] >= NUM_ZERO) &&
                        (wq_addr_c[i] < NUM_NW);
        wq_addr_r[i] <= wq_addr_c[i][IW-1:0];
        wq_data_r[i] <= wq_data_c[i][TW-1:0];
      end
    end
  end

  // result register, frees the sequencer while the transaction waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.status        <= status_r;
      out_data_r.block_address <= baddr_r;
      out_data_r.free_left     <= FREE_W'(free_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // free total never grows past the empty heap
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_INIT)
    else $error("free total above empty heap size");

  // a loaded result leaves the sequencer idle with the result shown
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result load did not return to idle");

  // the tag memory is never read and written in one cycle
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en_c && wr_en_c))
    else $error("tag memory read and write collide");

  // every accepted transaction occupies the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input not stalled after accept");

endmodule

>>> tb/tb_boundary_tag_first_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boundary_tag_first_fit_allocator
// self-checking bench for the first-fit boundary-tag heap allocator
// ----------------------------------------------------------------------------
// A behavioral copy of the heap (one signed tag per 8-byte word plus the free
// byte total) predicts the reply to every accepted request. Replies are
// compared field by field in arrival order. Directed tests cover the status
// codes, whole-block versus split allocation and merging on both sides.
// Random traffic then allocates and frees live blocks, mixed with bad
// addresses and double frees. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_boundary_tag_first_fit_allocator;
  import btalloc_pkg::*;

  localparam int HEAP_BYTES   = HEAP_BYTES_DEF;
  localparam int ELEM_BYTES   = ELEM_BYTES_DEF;
  localparam int NWORDS       = HEAP_BYTES / TAG_BYTES;
  localparam int MAX_GAP      = 17;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 525;
  // limit covers the worst reply, both idle windows and a wide margin
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  boundary_tag_first_fit_allocator #(
    .HEAP_BYTES(HEAP_BYTES),
    .ELEM_BYTES(ELEM_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // heap shadow: signed tag per word, free payload bytes
  // --------------------------------------------------------------------------
  int        heap_tag [NWORDS];
  int        shadow_free;
  out_item_t predicted_replies[$];
  int        live_addrs[$];   // user addresses of blocks believed in use
  int        freed_addrs[$];  // recently freed, for double-free attempts
  bit        no_idle = 1'b0;  // stretch with no gaps on either side
  int        errors = 0;
  int        cycles = 0;
  int        stall_left = 0;

  function automatic int tag_mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // writes the same tag into the leading and trailing word of a block
  function automatic void write_block(int w, int size);
    int tail_w;
    tail_w = w + tag_mag(size) / TAG_BYTES + 1;
    if (w >= 0 && w < NWORDS) heap_tag[w] = size;
    if (tail_w >= 0 && tail_w < NWORDS) heap_tag[tail_w] = size;
  endfunction

  // leading word of the following block, NWORDS when the chain stops
  function automatic int next_word(int w);
    int m, tail_w;
    m = tag_mag(heap_tag[w]);
    tail_w = w + m / TAG_BYTES + 1;
    if (m == 0 || tail_w >= NWORDS) return NWORDS;
    return tail_w + 1;
  endfunction

  function automatic void reset_heap();
    foreach (heap_tag[i]) heap_tag[i] = 0;
    shadow_free = HEAP_BYTES - PAIR_BYTES;
    write_block(0, shadow_free);
  endfunction

  // applies one request to the shadow heap and returns the reply it gives
  function automatic out_item_t predict_heap_reply(in_item_t item);
    out_item_t res;
    int need, w, t, extra, addr, lead, m, tail_w, start, size, gain, p, nx;
    bit found;
    res.status        = STAT_OK;
    res.block_address = '0;
    if (item.kind == KIND_ALLOC) begin
      need = int'(item.count) * ELEM_BYTES;
      need = (need + TAG_BYTES - 1) / TAG_BYTES * TAG_BYTES;
      if (item.count == 0) begin
        res.status = STAT_INVALID;
      end else if (need > shadow_free) begin
        res.status = STAT_EXCEEDS;
      end else begin
        w = 0;
        found = 1'b0;
        while (w < NWORDS && !found) begin
          t = heap_tag[w];
          if (t > 0 && t >= need) begin
            found = 1'b1;
            extra = t - need - PAIR_BYTES;
            if (extra < ELEM_BYTES) begin
              // too little left over for another block: hand out all of it
              write_block(w, -t);
              shadow_free -= t;
            end else begin
              write_block(w, -need);
              write_block(w + need / TAG_BYTES + 2, extra);
              shadow_free -= need + PAIR_BYTES;
            end
            res.block_address = ADDR_W'((w + 1) * TAG_BYTES);
          end else begin
            w = next_word(w);
          end
        end
        if (!found) res.status = STAT_NO_FIT;
      end
    end else begin
      addr = int'(item.address);
      if ((addr % TAG_BYTES) != 0 || addr < TAG_BYTES) begin
        res.status = STAT_INVALID;
      end else begin
        lead = addr / TAG_BYTES - 1;
        w = 0;
        while (w < lead && w < NWORDS) w = next_word(w);
        if (w != lead || lead >= NWORDS) begin
          res.status = STAT_INVALID;
        end else begin
          t = heap_tag[lead];
          m = tag_mag(t);
          tail_w = lead + m / TAG_BYTES + 1;
          if (t == 0 || tail_w >= NWORDS || heap_tag[tail_w] != t) begin
            res.status = STAT_INVALID;
          end else if (t > 0) begin
            res.status = STAT_ALREADY_FREE;
          end else begin
            start = lead;
            size = m;
            gain = m;
            if (lead > 0) begin
              p = heap_tag[lead - 1];
              if (p > 0 && p / TAG_BYTES + 2 <= lead) begin
                start = lead - p / TAG_BYTES - 2;
                size += p + PAIR_BYTES;
                gain += PAIR_BYTES;
              end
            end
            nx = tail_w + 1;
            if (nx < NWORDS && heap_tag[nx] > 0) begin
              size += heap_tag[nx] + PAIR_BYTES;
              gain += PAIR_BYTES;
            end
            write_block(start, size);
            shadow_free += gain;
          end
        end
      end
    end
    res.free_left = shadow_free[FREE_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // request side: one transaction, then the gap before the next one
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t item, output out_item_t reply);
    int gap;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reply = predict_heap_reply(item);
    predicted_replies.push_back(reply);
    // valid stays high straight into the next request when no gap is drawn
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic alloc_req(input int cnt, output out_item_t reply);
    in_item_t item;
    item.kind    = KIND_ALLOC;
    item.count   = COUNT_W'(cnt);
    item.address = ADDR_W'($urandom_range(0, 1023));
    send_item(item, reply);
    if (reply.status == STAT_OK) live_addrs.push_back(int'(reply.block_address));
  endtask

  task automatic free_req(input int addr, output out_item_t reply);
    in_item_t item;
    item.kind    = KIND_FREE;
    item.count   = COUNT_W'($urandom_range(0, 127));
    item.address = ADDR_W'(addr);
    send_item(item, reply);
    if (reply.status == STAT_OK) begin
      foreach (live_addrs[i]) begin
        if (live_addrs[i] == addr) begin
          live_addrs.delete(i);
          break;
        end
      end
      freed_addrs.push_back(addr);
      if (freed_addrs.size() > 8) void'(freed_addrs.pop_front());
    end
  endtask

  // --------------------------------------------------------------------------
  // reply side: stall for a drawn number of cycles once a reply shows up
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (out_valid && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%s: expected status=%0d addr=%0d free=%0d, got status=%0d addr=%0d free=%0d",
               what, want.status, want.block_address, want.free_left,
               got.status, got.block_address, got.free_left);
    end
  endtask

  // reply checker, oldest prediction first
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch("unexpected transaction", '0, out_data);
      end else begin
        want = predicted_replies.pop_front();
        if (out_data.status != want.status ||
            out_data.block_address != want.block_address ||
            out_data.free_left != want.free_left) begin
          report_mismatch("reply mismatch", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("boundary_tag_first_fit_allocator test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // directed tests, each one leaves the heap as a single free block
  // --------------------------------------------------------------------------

  // status codes and field extremes
  task automatic test_status_codes();
    out_item_t r, big;
    alloc_req(0, r);        // zero count
    alloc_req(126, big);    // largest count that fits takes the whole heap
    alloc_req(1, r);        // nothing left: above the free total
    free_req(int'(big.block_address), r);
    free_req(int'(big.block_address), r);  // double free
    free_req(0, r);         // below the first user area
    free_req(1023, r);      // misaligned, all address bits set
    free_req(1016, r);      // aligned but not on the block chain
  endtask

  // leftover below one element is handed out, otherwise the block splits
  task automatic test_whole_vs_split();
    out_item_t r, a;
    alloc_req(124, a);      // no spare payload at all
    free_req(int'(a.block_address), r);
    alloc_req(123, a);      // exactly one element to spare: split
    free_req(int'(a.block_address), r);  // merges with the remainder
  endtask

  // merging with nothing, the next block, then both neighbors
  task automatic test_coalescing();
    out_item_t r, a, b, c;
    alloc_req(1, a);
    alloc_req(2, b);
    alloc_req(3, c);
    free_req(int'(b.block_address), r);
    free_req(int'(a.block_address), r);
    free_req(int'(c.block_address), r);
  endtask

  // enough free bytes in total but no single block holds the request
  task automatic test_no_fit();
    out_item_t r, a, b, c;
    alloc_req(60, a);
    alloc_req(30, b);
    alloc_req(20, c);
    free_req(int'(a.block_address), r);
    alloc_req(65, r);
    free_req(int'(b.block_address), r);
    free_req(int'(c.block_address), r);
  endtask

  // --------------------------------------------------------------------------
  // random traffic: mostly alloc and free of live blocks, some noise
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int n_items);
    out_item_t r;
    int sel, pick, cnt;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 50 || live_addrs.size() == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)       cnt = 0;
        else if (pick < 80) cnt = $urandom_range(1, 12);
        else if (pick < 95) cnt = $urandom_range(13, 63);
        else                cnt = $urandom_range(64, 126);
        alloc_req(cnt, r);
      end else if (sel < 88) begin
        free_req(live_addrs[$urandom_range(0, live_addrs.size() - 1)], r);
      end else begin
        case ($urandom_range(0, 2))
          0: free_req($urandom_range(0, 1023), r);
          1: begin
            if (freed_addrs.size() != 0)
              free_req(freed_addrs[$urandom_range(0, freed_addrs.size() - 1)], r);
            else
              free_req($urandom_range(1, 127) * TAG_BYTES, r);
          end
          default: free_req($urandom_range(1, 127) * TAG_BYTES, r);
        endcase
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    reset_heap();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_status_codes();
    test_whole_vs_split();
    test_coalescing();
    test_no_fit();
    test_random_traffic(RANDOM_ITEMS);

    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("boundary_tag_first_fit_allocator test passed");
    end else begin
      $display("boundary_tag_first_fit_allocator test failed");
    end
    $finish;
  end

endmodule
